// ===== hdl/ptj_pkg.sv =====
`timescale 1ns / 1ps

package ptj_pkg;

  localparam int TIME_W   = 64;
  localparam int NOW_W    = 63;
  localparam int PERIOD_W = 62;
  localparam int OP_W     = 3;
  localparam int CHANGE_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = PERIOD_W;

  typedef enum logic [OP_W-1:0] {
    OP_START       = 3'd0,
    OP_RESET       = 3'd1,
    OP_EXPIRE      = 3'd2,
    OP_PRE_JUMP    = 3'd3,
    OP_POST_JUMP   = 3'd4,
    OP_READY_CHECK = 3'd5
  } op_t;

  typedef enum logic [CHANGE_W-1:0] {
    CHG_NONE        = 2'd0,
    CHG_SIM_ACTIVE  = 2'd1,
    CHG_DEACTIVATED = 2'd2
  } change_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD      = 2'd0,
    REG_EVENT_EN    = 2'd1,
    REG_SIM_AT_START = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

// ===== hdl/ptj_if.sv =====
`timescale 1ns / 1ps

interface ptj_in_if import ptj_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [NOW_W-1:0]    now_time;
  logic [CHANGE_W-1:0] jump_kind;
  logic                canceled;
  logic                from_wall_timer;

  modport source (
    output valid, operation, now_time, jump_kind, canceled, from_wall_timer,
    input  ready
  );
  modport sink (
    input  valid, operation, now_time, jump_kind, canceled, from_wall_timer,
    output ready
  );
endinterface

interface ptj_out_if import ptj_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     run_callback;
  logic                     wake_signal;
  logic                     ready_res;
  logic signed [TIME_W-1:0] next_call_time;
  logic signed [TIME_W-1:0] last_call_time;

  modport source (
    output valid, run_callback, wake_signal, ready_res, next_call_time, last_call_time,
    input  ready
  );
  modport sink (
    input  valid, run_callback, wake_signal, ready_res, next_call_time, last_call_time,
    output ready
  );
endinterface

interface ptj_cfg_if import ptj_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/ptj_rem.sv =====
`timescale 1ns / 1ps

// Restoring remainder, one dividend bit per cycle.
module ptj_rem import ptj_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [TIME_W-1:0]   dividend,
  input  logic [PERIOD_W-1:0] divisor,
  output logic [PERIOD_W-1:0] rem,
  output rem_status_t         status
);

  localparam int CNT_W = $clog2(TIME_W);

  logic [TIME_W-1:0]   dvd;
  logic [PERIOD_W-1:0] dsr;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;

  logic [PERIOD_W:0]   shifted;
  logic [PERIOD_W+1:0] diff;

  assign shifted = {rem, dvd[TIME_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[TIME_W-2:0], 1'b0};
      // no borrow: subtract fits, and the result is below the divisor
      if (!diff[PERIOD_W+1]) begin
        rem <= diff[PERIOD_W-1:0];
      end else begin
        rem <= shifted[PERIOD_W-1:0];
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== hdl/periodic_timer_time_jump_scheduler.sv =====
`timescale 1ns / 1ps

// Periodic timer scheduler: one item in, one result item out. An item is accepted, executed
// and delivered, and the result register lets the next item be accepted while a result
// waits. An expire that is not canceled or gated, whose next due time has fallen behind
// the current time with a nonzero period, runs the catch-up through a serial
// remainder unit that takes one dividend bit per cycle; the block then waits for the
// done flag and folds the remainder into the next due time.
// Configuration writes are taken every cycle.
module periodic_timer_time_jump_scheduler import ptj_pkg::*; (
  input  logic clk,
  input  logic rst,
  ptj_in_if.sink    items,
  ptj_out_if.source results,
  ptj_cfg_if.sink   cfg
);

  state_t state, state_next;

  // configuration
  logic [PERIOD_W-1:0] period;
  logic                event_en;
  logic                sim_at_start;

  // timer state
  logic [TIME_W-1:0] next_due;
  logic [TIME_W-1:0] last_due;
  logic [TIME_W-1:0] credit;
  logic              wall_open;

  // latched item
  logic [OP_W-1:0]     op;
  logic [NOW_W-1:0]    now_r;
  logic [CHANGE_W-1:0] change;
  logic                cancel;
  logic                from_wall;

  logic run, wake, rdy;
  logic out_valid;

  logic [TIME_W-1:0]   now64;
  logic [TIME_W-1:0]   per64;
  logic [TIME_W-1:0]   nx;
  logic                nx_behind;
  logic                expire_ok;
  logic                rem_start;
  logic [PERIOD_W-1:0] rem;
  rem_status_t         rem_st;
  logic                in_ready;
  logic                in_take;
  logic                out_free;

  assign now64     = {1'b0, now_r};
  assign per64     = {2'b00, period};
  assign nx        = next_due + per64;
  assign nx_behind = $signed(nx) < $signed(now64);
  assign expire_ok = !cancel && !(from_wall && !wall_open);
  assign out_free  = !out_valid || results.ready;
  assign in_take   = items.valid && in_ready;

  ptj_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (now64 + ~nx),   // gap - 1
    .divisor  (period),
    .rem      (rem),
    .status   (rem_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rem_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (items.valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (op == OP_EXPIRE && expire_ok && nx_behind && period != '0) begin
          rem_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (rem_st.done) state_next = ST_FIX;
      end
      ST_FIX: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign items.ready = in_ready;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period       <= '0;
      event_en     <= 1'b0;
      sim_at_start <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PERIOD:       period       <= cfg.data;
        REG_EVENT_EN:     event_en     <= cfg.data[0];
        REG_SIM_AT_START: sim_at_start <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op        <= items.operation;
      now_r     <= items.now_time;
      change    <= items.jump_kind;
      cancel    <= items.canceled;
      from_wall <= items.from_wall_timer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_due  <= '0;
      last_due  <= '0;
      credit    <= '0;
      wall_open <= 1'b1;
      run       <= 1'b0;
      wake      <= 1'b0;
      rdy       <= 1'b0;
    end else begin
      if (in_take) begin
        run  <= 1'b0;
        wake <= 1'b0;
        rdy  <= 1'b0;
      end
      if (state == ST_EXEC) begin
        case (op)
          OP_START: begin
            last_due  <= now64;
            next_due  <= now64 + per64;
            credit    <= '0;
            wall_open <= !sim_at_start;
          end
          OP_RESET: begin
            next_due <= now64 + per64;
          end
          OP_EXPIRE: begin
            if (expire_ok) begin
              run      <= 1'b1;
              last_due <= now64;
              if (!nx_behind) begin
                next_due <= nx;
              end else if (period == '0) begin
                next_due <= now64;
              end
            end
          end
          OP_PRE_JUMP: begin
            if (now_r != '0) credit <= next_due - now64;
          end
          OP_POST_JUMP: begin
            if (change == CHG_SIM_ACTIVE) begin
              wall_open <= 1'b0;
              if (now_r != '0) begin
                credit <= '0;
                if (credit != '0) begin
                  next_due <= now64 - credit + per64;
                  last_due <= now64 - credit;
                end
              end
            end else if (change == CHG_NONE) begin
              if (!($signed(now64) < $signed(next_due))) begin
                wake <= event_en && !cancel;
              end else if ($signed(now64) < $signed(last_due)) begin
                next_due <= now64 + per64;
                last_due <= now64;
              end
            end
          end
          OP_READY_CHECK: begin
            rdy <= !($signed(now64) < $signed(next_due));
          end
          default: ;
        endcase
      end
      // caught up: now - 1 - rem + period
      if (state == ST_FIX) begin
        next_due <= now64 + per64 + ~{2'b00, rem};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      results.run_callback   <= run;
      results.wake_signal    <= wake;
      results.ready_res      <= rdy;
      results.next_call_time <= next_due;
      results.last_call_time <= last_due;
    end
  end

  assign results.valid = out_valid;

endmodule

// ===== sim/periodic_timer_time_jump_scheduler_tb.sv =====
`timescale 1ns / 1ps

module periodic_timer_time_jump_scheduler_tb;
  import ptj_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;

  localparam logic [NOW_W-1:0]    TIME_MAX   = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
  // codes the package leaves unnamed; the block must ignore them
  localparam logic [OP_W-1:0]     OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0]     OP_UNUSED_7 = 3'd7;
  localparam logic [CHANGE_W-1:0] CHG_UNUSED  = 2'd3;

  typedef struct packed {
    logic              run;
    logic              wake;
    logic              rdy;
    logic [TIME_W-1:0] next_t;
    logic [TIME_W-1:0] last_t;
  } timer_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptj_in_if  items ();
  ptj_out_if results ();
  ptj_cfg_if cfg ();

  periodic_timer_time_jump_scheduler dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg)
  );

  // timer state as the block should hold it
  logic [PERIOD_W-1:0] cfg_period       = '0;
  logic                cfg_event_en     = 1'b0;
  logic                cfg_sim_at_start = 1'b0;
  logic [TIME_W-1:0]   due_next         = '0;
  logic [TIME_W-1:0]   due_last         = '0;
  logic [TIME_W-1:0]   jump_credit      = '0;
  logic                wall_open        = 1'b1;

  timer_out_t sched_q[$];
  int fails       = 0;
  int sent_count  = 0;
  int stall_left  = 0;
  int quiet_cycles = 0;
  bit idle_on     = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [NOW_W-1:0] pick_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TIME_MAX - $urandom_range(0, 1000);
      2: return NOW_W'($urandom_range(1, 100000));
      default: return NOW_W'(rand64());
    endcase
  endfunction

  // next clock reading: often about one period on, else small, late, random or backward steps
  function automatic logic [NOW_W-1:0] step_clock(logic [NOW_W-1:0] t, logic [TIME_W-1:0] per);
    logic [TIME_W-1:0] d;
    case ($urandom_range(0, 7))
      0: d = 64'($urandom_range(0, 50));
      1, 2: d = per;
      3: d = per - $urandom_range(0, 3);
      4: d = per * $urandom_range(2, 40) + $urandom_range(0, 999);
      5: d = rand64() >> $urandom_range(1, 63);
      6: d = -(64'($urandom_range(1, 5000)));
      default: return pick_time();
    endcase
    return NOW_W'({1'b0, t} + d);
  endfunction

  function automatic timer_out_t advance_timer(logic [OP_W-1:0] op, logic [NOW_W-1:0] now_in,
                                               logic [CHANGE_W-1:0] chg, logic can,
                                               logic from_wall);
    timer_out_t r;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] nx;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] steps;
    logic [TIME_W-1:0] c;
    now = {1'b0, now_in};
    per = {2'b00, cfg_period};
    r = '0;
    case (op)
      OP_START: begin
        due_last    = now;
        due_next    = now + per;
        jump_credit = '0;
        wall_open   = !cfg_sim_at_start;
      end
      OP_RESET: due_next = now + per;
      OP_EXPIRE: begin
        if (!can && !(from_wall && !wall_open)) begin
          nx = due_next + per;
          due_last = now;
          if ($signed(nx) < $signed(now)) begin
            if (per == '0) begin
              nx = now;
            end else begin
              // round up to the first period boundary at or after now
              gap   = now - nx;
              steps = 64'd1 + (gap - 64'd1) / per;
              nx    = nx + steps * per;
            end
          end
          due_next = nx;
          r.run = 1'b1;
        end
      end
      OP_PRE_JUMP: begin
        if (now != '0) jump_credit = due_next - now;
      end
      OP_POST_JUMP: begin
        if (chg == CHG_SIM_ACTIVE) begin
          wall_open = 1'b0;
          if (now != '0) begin
            c = jump_credit;
            jump_credit = '0;
            if (c != '0) begin
              due_next = now - c + per;
              due_last = now - c;
            end
          end
        end else if (chg == CHG_NONE) begin
          if (!($signed(now) < $signed(due_next))) begin
            r.wake = cfg_event_en && !can;
          end else if ($signed(now) < $signed(due_last)) begin
            due_next = now + per;
            due_last = now;
          end
        end
      end
      OP_READY_CHECK: r.rdy = !($signed(now) < $signed(due_next));
      default: ;
    endcase
    r.next_t = due_next;
    r.last_t = due_last;
    return r;
  endfunction

  // valid stays high after acceptance; whoever waits next must lower it
  task automatic send_item(logic [OP_W-1:0] op, logic [NOW_W-1:0] now_in,
                           logic [CHANGE_W-1:0] chg = CHG_NONE, logic can = 1'b0,
                           logic from_wall = 1'b0);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    items.valid           <= 1'b1;
    items.operation       <= op;
    items.now_time        <= now_in;
    items.jump_kind       <= chg;
    items.canceled        <= can;
    items.from_wall_timer <= from_wall;
    do @(posedge clk); while (!items.ready);
    sched_q.push_back(advance_timer(op, now_in, chg, can, from_wall));
    sent_count++;
  endtask

  task automatic wait_results_drained();
    items.valid <= 1'b0;
    do @(posedge clk); while (sched_q.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic write_config(logic [PERIOD_W-1:0] per, logic ev, logic sim);
    write_reg(REG_PERIOD, per);
    write_reg(REG_EVENT_EN, CFG_DATA_W'(ev));
    write_reg(REG_SIM_AT_START, CFG_DATA_W'(sim));
    cfg.valid <= 1'b0;
    cfg_period       = per;
    cfg_event_en     = ev;
    cfg_sim_at_start = sim;
  endtask

  task automatic check_field(string tag, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s expected %h got %h", $time, tag, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    timer_out_t want;
    if (!rst && results.valid && results.ready) begin
      if (sched_q.size() == 0) begin
        fails++;
        $display("%0t: result item with none pending, expected nothing got next %h last %h",
                 $time, results.next_call_time, results.last_call_time);
      end else begin
        want = sched_q.pop_front();
        check_field("run_callback", TIME_W'(want.run), TIME_W'(results.run_callback));
        check_field("wake_signal", TIME_W'(want.wake), TIME_W'(results.wake_signal));
        check_field("ready_res", TIME_W'(want.rdy), TIME_W'(results.ready_res));
        check_field("next_call_time", want.next_t, results.next_call_time);
        check_field("last_call_time", want.last_t, results.last_call_time);
      end
    end
  end

  // result backpressure in bursts of random length, started only while idle_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      results.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      results.ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      results.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[periodic_timer_time_jump_scheduler] ERROR");
      $finish;
    end
  end

  // reset values: zero period, wall source open
  task automatic test_reset_defaults();
    send_item(OP_READY_CHECK, '0);
    send_item(OP_EXPIRE, '0, CHG_NONE, 1'b0, 1'b1);
  endtask

  task automatic test_schedule_basics();
    wait_results_drained();
    write_config(1000, 1'b1, 1'b0);
    send_item(OP_START, 5000);
    send_item(OP_READY_CHECK, 5999);
    send_item(OP_READY_CHECK, 6000);
    send_item(OP_EXPIRE, 6000, CHG_NONE, 1'b1, 1'b0);
    send_item(OP_EXPIRE, 6000, CHG_NONE, 1'b0, 1'b1);
    // several periods missed
    send_item(OP_EXPIRE, 10500);
    send_item(OP_RESET, 20000);
  endtask

  task automatic test_time_jumps();
    send_item(OP_PRE_JUMP, 20400);
    send_item(OP_PRE_JUMP, '0);
    send_item(OP_POST_JUMP, 30000, CHG_SIM_ACTIVE);
    send_item(OP_EXPIRE, 31000, CHG_NONE, 1'b0, 1'b1);
    send_item(OP_POST_JUMP, '0, CHG_SIM_ACTIVE);
    send_item(OP_POST_JUMP, 40000, CHG_SIM_ACTIVE);
    send_item(OP_POST_JUMP, TIME_MAX, CHG_NONE, 1'b1);
    send_item(OP_POST_JUMP, TIME_MAX, CHG_NONE);
    send_item(OP_POST_JUMP, 100, CHG_NONE);
    send_item(OP_POST_JUMP, 5, CHG_DEACTIVATED);
    send_item(OP_POST_JUMP, 5, CHG_UNUSED);
    send_item(OP_UNUSED_6, 77777);
    send_item(OP_UNUSED_7, TIME_MAX, CHG_UNUSED, 1'b1, 1'b1);
  endtask

  task automatic test_period_extremes();
    wait_results_drained();
    write_config(PERIOD_MAX, 1'b0, 1'b1);
    send_item(OP_START, TIME_MAX);
    send_item(OP_EXPIRE, TIME_MAX, CHG_NONE, 1'b0, 1'b1);
    wait_results_drained();
    write_config('0, 1'b1, 1'b1);
    send_item(OP_START, 100);
    send_item(OP_EXPIRE, 50);
    send_item(OP_EXPIRE, 200);
  endtask

  task automatic run_random_phase(int n);
    logic [NOW_W-1:0]    clock_now;
    logic [TIME_W-1:0]   per;
    logic [CHANGE_W-1:0] chg;
    int stop_at;
    stop_at   = sent_count + n;
    per       = {2'b00, cfg_period};
    clock_now = pick_time();
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 40) == 0) wait_results_drained();
      if ($urandom_range(0, 9) < 7) begin
        // a started timer followed by a walk of expiries, checks, resets and jumps
        send_item(OP_START, clock_now, CHANGE_W'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(2, 10)) begin
          clock_now = step_clock(clock_now, per);
          case ($urandom_range(0, 7))
            0, 1, 2: send_item(OP_EXPIRE, clock_now, CHG_NONE, $urandom_range(0, 7) == 0,
                               1'($urandom_range(0, 1)));
            3: send_item(OP_READY_CHECK, clock_now);
            4: send_item(OP_RESET, clock_now);
            default: begin
              send_item(OP_PRE_JUMP, ($urandom_range(0, 15) == 0) ? '0 : clock_now);
              clock_now = step_clock(clock_now, per);
              case ($urandom_range(0, 5))
                0, 1, 2: chg = CHG_NONE;
                3, 4: chg = CHG_SIM_ACTIVE;
                default: chg = ($urandom_range(0, 1) != 0) ? CHG_DEACTIVATED : CHG_UNUSED;
              endcase
              send_item(OP_POST_JUMP, ($urandom_range(0, 15) == 0) ? '0 : clock_now, chg,
                        $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
            end
          endcase
        end
      end else begin
        send_item(OP_W'($urandom_range(0, 7)), pick_time(), CHANGE_W'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [PERIOD_W-1:0] per;
    for (int ph = 0; ph < 8; ph++) begin
      wait_results_drained();
      idle_on = (ph < 6);
      case (ph % 4)
        0: per = PERIOD_W'($urandom_range(1, 1000));
        1: per = PERIOD_W'(rand64());
        2: per = (ph < 4) ? '0 : PERIOD_MAX;
        default: per = PERIOD_W'($urandom_range(1, 1 << 20));
      endcase
      write_config(per, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_random_phase(150);
    end
  endtask

  initial begin
    items.valid           <= 1'b0;
    items.operation       <= OP_START;
    items.now_time        <= '0;
    items.jump_kind       <= CHG_NONE;
    items.canceled        <= 1'b0;
    items.from_wall_timer <= 1'b0;
    cfg.valid             <= 1'b0;
    cfg.index             <= REG_PERIOD;
    cfg.data              <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_schedule_basics();
    test_time_jumps();
    test_period_extremes();
    test_random_traffic();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("[periodic_timer_time_jump_scheduler] OK");
    else
      $display("[periodic_timer_time_jump_scheduler] ERROR");
    $finish;
  end

endmodule

// ===== periodic_timer_time_jump_scheduler.f =====
hdl/ptj_pkg.sv
hdl/ptj_if.sv
hdl/ptj_rem.sv
hdl/periodic_timer_time_jump_scheduler.sv
sim/periodic_timer_time_jump_scheduler_tb.sv
